[sv/sap_pkg.sv]
// Shared widths, register indexes, payload structs and helpers of the shelf atlas packer.
package sap_pkg;

	// Field widths of the request and response words.
	localparam int W_GLYPH  = 11;
	localparam int W_RES    = 13;
	localparam int W_ATLAS  = 13;
	localparam int W_POS    = 13;
	localparam int W_MARGIN = 12;

	// Internal widths of the margin arithmetic.
	localparam int W_EFFECT = 11;
	localparam int W_DIM    = 13;
	localparam int W_PAD    = 13;

	// Row markers are kept modulo 2^COORD_BITS.
	localparam int COORD_BITS = 14;
	// Alignment of the row markers; must be a power of two.
	localparam int ROW_ALIGN  = 4;

	localparam int W_ALIGNED = COORD_BITS + 1;
	localparam int W_SUM     = ((W_ALIGNED > W_PAD) ? W_ALIGNED : W_PAD) + 1;

	// Division by three through a reciprocal, exact for 12-bit dividends.
	localparam int W_HALF       = W_RES - 1;
	localparam int RECIP3_SHIFT = 13;
	localparam logic [W_HALF-1:0] RECIP3 = W_HALF'(2731);

	// Configuration register indexes.
	localparam int W_CFG_INDEX = 2;
	localparam logic [W_CFG_INDEX-1:0] CFG_ATLAS_WIDTH  = 2'd0;
	localparam logic [W_CFG_INDEX-1:0] CFG_ATLAS_HEIGHT = 2'd1;
	localparam logic [W_CFG_INDEX-1:0] CFG_DF_MODE      = 2'd2;

	localparam logic [W_ATLAS-1:0] ATLAS_SIZE_RESET = W_ATLAS'(1024);

	typedef struct packed {
		logic [W_MARGIN-1:0] margin;
		logic [W_PAD-1:0]    pad_w;
		logic [W_PAD-1:0]    pad_h;
	} sap_box_t;

	typedef struct packed {
		logic [W_ATLAS-1:0] atlas_width;
		logic [W_ATLAS-1:0] atlas_height;
	} sap_geom_t;

	typedef struct packed {
		logic                fits;
		logic [W_POS-1:0]    place_x;
		logic [W_POS-1:0]    place_y;
		logic [W_MARGIN-1:0] texel_margin;
	} sap_result_t;

	localparam logic [W_ALIGNED-1:0] ALIGN_ADD  = W_ALIGNED'(ROW_ALIGN - 1);
	localparam logic [W_ALIGNED-1:0] ALIGN_MASK = ~ALIGN_ADD;

	// Rounds a row marker up to the next multiple of ROW_ALIGN.
	function automatic logic [W_ALIGNED-1:0] align_up(input logic [COORD_BITS-1:0] v);
		return ({1'b0, v} + ALIGN_ADD) & ALIGN_MASK;
	endfunction

endpackage

[sv/sap_req_if.sv]
// Request channel of the shelf atlas packer: one glyph box per word.
interface sap_req_if;
	logic                         valid;
	logic                         ready;
	logic [sap_pkg::W_GLYPH-1:0] glyph_width;
	logic [sap_pkg::W_GLYPH-1:0] glyph_height;
	logic [sap_pkg::W_RES-1:0]   font_res_vertical;

	modport source (output valid, glyph_width, glyph_height, font_res_vertical, input ready);
	modport sink   (input valid, glyph_width, glyph_height, font_res_vertical, output ready);
endinterface

[sv/sap_rsp_if.sv]
// Response channel of the shelf atlas packer: one placement per word.
interface sap_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          fits;
	logic [sap_pkg::W_POS-1:0]    place_x;
	logic [sap_pkg::W_POS-1:0]    place_y;
	logic [sap_pkg::W_MARGIN-1:0] texel_margin;

	modport source (output valid, fits, place_x, place_y, texel_margin, input ready);
	modport sink   (input valid, fits, place_x, place_y, texel_margin, output ready);
endinterface

[sv/sap_margin.sv]
// Margin unit: effect margin, texel margin and padded box size of one glyph.
module sap_margin (
	input  logic [sap_pkg::W_GLYPH-1:0] glyph_width,
	input  logic [sap_pkg::W_GLYPH-1:0] glyph_height,
	input  logic [sap_pkg::W_RES-1:0]   font_res_vertical,
	input  logic                        df_mode,
	output sap_pkg::sap_box_t           box
);
	import sap_pkg::*;

	logic [W_HALF-1:0]      res_half;
	logic [2*W_HALF-1:0]    prod;
	logic [W_EFFECT-1:0]    res_sixth;
	logic [W_EFFECT-1:0]    effect;
	logic [W_GLYPH-1:0]     big_side;
	logic [W_DIM-1:0]       dim;
	logic [W_DIM-3:0]       quarter;
	logic [W_DIM-3:0]       base_margin;
	logic [W_MARGIN-1:0]    margin;

	// res/6 is taken as (res/2)/3, the third by a reciprocal multiply.
	assign res_half  = font_res_vertical[W_RES-1:1];
	assign prod      = res_half * RECIP3;
	assign res_sixth = prod[RECIP3_SHIFT +: W_EFFECT];

	always_comb begin
		if (!df_mode) begin
			effect = '0;
		end else if (res_sixth < W_EFFECT'(2)) begin
			effect = W_EFFECT'(2);
		end else begin
			effect = res_sixth;
		end
	end

	assign big_side = (glyph_width > glyph_height) ? glyph_width : glyph_height;
	assign dim      = W_DIM'(big_side) + (W_DIM'(effect) << 1);
	assign quarter  = dim[W_DIM-1:2];

	assign base_margin = (quarter < (W_DIM-2)'(2)) ? (W_DIM-2)'(2) : quarter;
	assign margin      = W_MARGIN'(base_margin) + W_MARGIN'(effect);

	assign box.margin = margin;
	assign box.pad_w  = W_PAD'(glyph_width) + (W_PAD'(margin) << 1);
	assign box.pad_h  = W_PAD'(glyph_height) + (W_PAD'(margin) << 1);

endmodule

[sv/sap_place.sv]
// Placement unit: row markers and the shelf fit decision for one padded box.
module sap_place (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  sap_pkg::sap_box_t   box,
	input  sap_pkg::sap_geom_t  geom,
	output sap_pkg::sap_result_t result
);
	import sap_pkg::*;

	logic [COORD_BITS-1:0] row_base_q;
	logic [COORD_BITS-1:0] row_fill_q;
	logic [COORD_BITS-1:0] row_top_q;

	logic [W_ALIGNED-1:0] ax;
	logic [W_ALIGNED-1:0] ay;
	logic [W_ALIGNED-1:0] az;

	logic [W_SUM-1:0] pw_x;
	logic [W_SUM-1:0] ph_x;
	logic [W_SUM-1:0] m_x;
	logic [W_SUM-1:0] tw_x;
	logic [W_SUM-1:0] th_x;

	logic             fit_cur;
	logic             fit_new;
	logic [W_SUM-1:0] px_cur;
	logic [W_SUM-1:0] py_cur;
	logic [W_SUM-1:0] fill_cur;
	logic [W_SUM-1:0] top_cur;
	logic             grow;
	logic [W_SUM-1:0] py_new;
	logic [W_SUM-1:0] fill_new;
	logic [W_SUM-1:0] top_new;

	assign ax = align_up(row_fill_q);
	assign ay = align_up(row_top_q);
	assign az = align_up(row_base_q);

	assign pw_x = W_SUM'(box.pad_w);
	assign ph_x = W_SUM'(box.pad_h);
	assign m_x  = W_SUM'(box.margin);
	assign tw_x = W_SUM'(geom.atlas_width);
	assign th_x = W_SUM'(geom.atlas_height);

	// All operands are non-negative, so the free space compares are done as
	// sums against the atlas size.
	assign fit_cur = (pw_x + W_SUM'(ax) <= tw_x) && (ph_x + W_SUM'(az) <= th_x);
	assign fit_new = (pw_x <= tw_x) && (ph_x + W_SUM'(row_top_q) <= th_x);

	assign px_cur   = W_SUM'(ax) + m_x;
	assign py_cur   = W_SUM'(az) + m_x;
	assign fill_cur = px_cur + pw_x;
	// The tallest-box test uses the unrounded row base.
	assign top_cur  = W_SUM'(row_base_q) + ph_x;
	assign grow     = top_cur > W_SUM'(row_top_q);

	assign py_new   = W_SUM'(ay) + m_x;
	assign fill_new = m_x + pw_x;
	assign top_new  = W_SUM'(ay) + ph_x;

	always_comb begin
		result.texel_margin = box.margin;
		if (fit_cur) begin
			result.fits    = 1'b1;
			result.place_x = px_cur[W_POS-1:0];
			result.place_y = py_cur[W_POS-1:0];
		end else if (fit_new) begin
			result.fits    = 1'b1;
			result.place_x = m_x[W_POS-1:0];
			result.place_y = py_new[W_POS-1:0];
		end else begin
			result.fits    = 1'b0;
			result.place_x = '0;
			result.place_y = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_base_q <= '0;
			row_fill_q <= '0;
			row_top_q  <= '0;
		end else if (commit) begin
			if (fit_cur) begin
				row_fill_q <= fill_cur[COORD_BITS-1:0];
				if (grow) begin
					row_top_q <= top_cur[COORD_BITS-1:0];
				end
			end else if (fit_new) begin
				row_base_q <= ay[COORD_BITS-1:0];
				row_fill_q <= fill_new[COORD_BITS-1:0];
				row_top_q  <= top_new[COORD_BITS-1:0];
			end
		end
	end

endmodule

[sv/shelf_atlas_packer_unit.sv]
// Top level of the shelf atlas packer: configuration registers, pipeline and handshakes.

// The packer places glyph boxes into a texture atlas row by row (shelf packing).
// Each request word carries a glyph width, height and vertical font resolution;
// each yields exactly one response word with a fit flag, the glyph origin and the
// texel margin that pads the glyph on every side. The block takes one word per
// clock cycle while the response side is not stalled. Each word passes a request
// register, a margin stage register (after one 12 by 12 bit multiply for the effect
// margin) and the response register that the placement stage loads. The row markers
// are updated in the same cycle as the response register is loaded, which is what
// holds the rate at one word per cycle while responses are taken. Each stage has its
// own valid bit, so the channel keeps taking words while a finished response waits;
// ready falls only when all three stages are full and the response is not being
// taken. A box that does not fit returns fits low with a zero position and leaves the
// row markers as they were. The atlas size (reset 1024 by 1024) and the distance
// field mode (reset greyscale) are to be written through the configuration port only
// while no word is in flight; the block itself does not enforce this.
module shelf_atlas_packer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sap_pkg::W_CFG_INDEX-1:0] cfg_index,
	input  logic [sap_pkg::W_ATLAS-1:0]     cfg_data,
	sap_req_if.sink                          req,
	sap_rsp_if.source                        rsp
);
	import sap_pkg::*;

	// Configuration registers.
	logic [W_ATLAS-1:0] atlas_width_q;
	logic [W_ATLAS-1:0] atlas_height_q;
	logic               df_mode_q;

	// Request register.
	logic               valid_s1;
	logic [W_GLYPH-1:0] glyph_width_s1;
	logic [W_GLYPH-1:0] glyph_height_s1;
	logic [W_RES-1:0]   font_res_s1;

	// Margin stage register.
	logic     valid_s2;
	sap_box_t box_s2;

	// Response register.
	logic        rsp_valid_q;
	sap_result_t rsp_q;

	sap_box_t    box_d;
	sap_geom_t   geom;
	sap_result_t result_d;

	logic ready_s1;
	logic ready_s2;
	logic ready_out;
	logic commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_width_q  <= ATLAS_SIZE_RESET;
			atlas_height_q <= ATLAS_SIZE_RESET;
			df_mode_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ATLAS_WIDTH:  atlas_width_q  <= cfg_data;
				CFG_ATLAS_HEIGHT: atlas_height_q <= cfg_data;
				CFG_DF_MODE:      df_mode_q      <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// Each stage may load when it is empty or its word moves on in this cycle.
	assign ready_out = !rsp_valid_q || rsp.ready;
	assign ready_s2  = !valid_s2 || ready_out;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign commit    = valid_s2 && ready_out;

	assign req.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && req.valid) begin
			glyph_width_s1  <= req.glyph_width;
			glyph_height_s1 <= req.glyph_height;
			font_res_s1     <= req.font_res_vertical;
		end
	end

	sap_margin u_margin (
		.glyph_width       (glyph_width_s1),
		.glyph_height      (glyph_height_s1),
		.font_res_vertical (font_res_s1),
		.df_mode           (df_mode_q),
		.box               (box_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			box_s2 <= box_d;
		end
	end

	assign geom.atlas_width  = atlas_width_q;
	assign geom.atlas_height = atlas_height_q;

	// The row markers move on the same edge that loads the response register.
	sap_place u_place (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.box    (box_s2),
		.geom   (geom),
		.result (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ready_out) begin
			rsp_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q <= result_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.fits         = rsp_q.fits;
	assign rsp.place_x      = rsp_q.place_x;
	assign rsp.place_y      = rsp_q.place_y;
	assign rsp.texel_margin = rsp_q.texel_margin;

	// Back-pressure on the request side only when every stage holds a word.
	a_ready_low_only_when_full: assert property (
		@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (valid_s1 && valid_s2 && rsp_valid_q && !rsp.ready)
	) else $error("request ready low while the pipeline has room");

	// A word in the margin stage is kept while the response is stalled.
	a_s2_holds_on_stall: assert property (
		@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rsp_valid_q && !rsp.ready) |=> (valid_s2 && $stable(box_s2))
	) else $error("margin stage word lost during a response stall");

	// The row markers are only advanced when a response word is loaded.
	a_commit_loads_response: assert property (
		@(posedge clk) disable iff (!arst_n)
		commit |=> rsp_valid_q
	) else $error("placement committed without a response word");

endmodule

[dv/testbench.sv]
// Self-checking testbench of the shelf atlas packer, with its own placement predictor.

// How the run works
// -----------------
// An initial block puts glyph requests on a queue of pending words and writes the atlas
// registers between phases, once the block has gone quiet. A clocked driver takes words
// from that queue onto the request channel. At each accepted request it runs the shelf
// placement predictor, which keeps its own copy of the row markers and the registers,
// and queues the placement that the block should answer with. A clocked monitor takes
// response words and compares each one, field by field, with the oldest queued
// placement. A watchdog ends the run if nothing moves on either channel for too long.
//
// The phases change the atlas size and the margin mode so that boxes land in the
// current row, start new rows, and are refused. Some settings make the signed room
// checks go negative: a row filled past a width that is then shrunk, or a tallest box
// above a height that is then lowered. A zero-sized atlas and a one-texel atlas refuse
// everything.
module testbench;
	import sap_pkg::*;

	// Long enough for the longest receiver stall and a register pause, many times over.
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic [W_GLYPH-1:0] gw;
		logic [W_GLYPH-1:0] gh;
		logic [W_RES-1:0]   res;
	} glyph_req_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [W_CFG_INDEX-1:0] cfg_index;
	logic [W_ATLAS-1:0]     cfg_data;

	sap_req_if req_ch ();
	sap_rsp_if rsp_ch ();

	shelf_atlas_packer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Words waiting to be driven, and placements waiting for their response word.
	glyph_req_t  pend_q[$];
	sap_result_t placements_q[$];

	// The predictor's copy of the registers and the row markers.
	logic [W_ATLAS-1:0]    atlas_w_cfg;
	logic [W_ATLAS-1:0]    atlas_h_cfg;
	logic                  df_mode_cfg;
	logic [COORD_BITS-1:0] shelf_base;
	logic [COORD_BITS-1:0] shelf_fill;
	logic [COORD_BITS-1:0] shelf_top;

	int send_idle_pct;
	int recv_idle_pct;
	int mismatches;
	int words_sent;
	int words_checked;
	int placed_cnt;
	int refused_cnt;
	int setting_cnt;
	int quiet_cycles;

	always #1 clk = ~clk;

	// Rounds a marker up to the row alignment; the marker is never negative here.
	function automatic int round_to_row(input int v);
		return ((v + ROW_ALIGN - 1) / ROW_ALIGN) * ROW_ALIGN;
	endfunction

	// Works out the placement of one glyph and moves the row markers as the block should.
	// The room checks are signed: a marker may already lie beyond the atlas edge.
	function automatic sap_result_t place_glyph(input glyph_req_t g);
		int          effect, bigger, m, pw, ph, tw, th, base, top, fx, ty, bz;
		sap_result_t r;
		effect = 0;
		if (df_mode_cfg) begin
			effect = g.res / 6;
			if (effect < 2)
				effect = 2;
		end
		bigger = (g.gw > g.gh) ? g.gw : g.gh;
		m = (bigger + 2 * effect) / 4;
		if (m < 2)
			m = 2;
		m = m + effect;
		pw   = g.gw + 2 * m;
		ph   = g.gh + 2 * m;
		tw   = atlas_w_cfg;
		th   = atlas_h_cfg;
		base = shelf_base;
		top  = shelf_top;
		fx   = round_to_row(shelf_fill);
		ty   = round_to_row(top);
		bz   = round_to_row(base);
		r.fits         = 1'b0;
		r.place_x      = '0;
		r.place_y      = '0;
		r.texel_margin = W_MARGIN'(m);
		if (pw <= tw - fx && ph <= th - bz) begin
			// Room left in the current row. The tallest-box marker follows the
			// unrounded row base, not the rounded one used for the position.
			r.fits     = 1'b1;
			r.place_x  = W_POS'(fx + m);
			r.place_y  = W_POS'(bz + m);
			shelf_fill = COORD_BITS'(fx + m + pw);
			if (base + ph > top)
				shelf_top = COORD_BITS'(base + ph);
		end else if (pw <= tw && ph <= th - top) begin
			// A new row above the tallest box so far.
			r.fits     = 1'b1;
			r.place_x  = W_POS'(m);
			r.place_y  = W_POS'(ty + m);
			shelf_base = COORD_BITS'(ty);
			shelf_fill = COORD_BITS'(m + pw);
			shelf_top  = COORD_BITS'(ty + ph);
		end
		return r;
	endfunction

	task automatic queue_glyph(input int gw, input int gh, input int res);
		glyph_req_t g;
		g.gw  = W_GLYPH'(gw);
		g.gh  = W_GLYPH'(gh);
		g.res = W_RES'(res);
		pend_q.insert(pend_q.size(), g);
	endtask

	// Mostly small glyphs with the odd medium or huge one; resolutions mostly low so that
	// the effect margin stays moderate, with the whole range now and then.
	task automatic queue_random_glyphs(input int n);
		int sel, gw, gh, res;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 4) begin
				gw = $urandom_range(2047);
				gh = $urandom_range(2047);
			end else if (sel < 20) begin
				gw = $urandom_range(255);
				gh = $urandom_range(255);
			end else begin
				gw = $urandom_range(63);
				gh = $urandom_range(63);
			end
			if ($urandom_range(3) == 0)
				res = $urandom_range(8191);
			else
				res = $urandom_range(120);
			queue_glyph(gw, gh, res);
		end
	endtask

	// Waits until every word has been taken and answered, lets the pipeline settle,
	// then writes all three registers on consecutive edges.
	task automatic set_atlas(input int aw, input int ah, input bit df);
		while (pend_q.size() != 0 || req_ch.valid || placements_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ATLAS_WIDTH;
		cfg_data  <= W_ATLAS'(aw);
		@(posedge clk);
		cfg_index <= CFG_ATLAS_HEIGHT;
		cfg_data  <= W_ATLAS'(ah);
		@(posedge clk);
		cfg_index <= CFG_DF_MODE;
		cfg_data  <= W_ATLAS'(df);
		@(posedge clk);
		cfg_we      <= 1'b0;
		atlas_w_cfg = W_ATLAS'(aw);
		atlas_h_cfg = W_ATLAS'(ah);
		df_mode_cfg = df;
		setting_cnt++;
		@(negedge clk);
	endtask

	// Request driver: a word stays on the channel until it is taken, and the next one
	// follows on the same edge unless the sender chooses to idle.
	always @(posedge clk) begin
		glyph_req_t held_glyph;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				held_glyph.gw  = req_ch.glyph_width;
				held_glyph.gh  = req_ch.glyph_height;
				held_glyph.res = req_ch.font_res_vertical;
				placements_q.insert(placements_q.size(), place_glyph(held_glyph));
				words_sent++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					held_glyph = pend_q.pop_front();
					req_ch.valid             <= 1'b1;
					req_ch.glyph_width       <= held_glyph.gw;
					req_ch.glyph_height      <= held_glyph.gh;
					req_ch.font_res_vertical <= held_glyph.res;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: ready is chosen afresh every cycle, and each word taken is
	// compared with the oldest placement still waiting.
	always @(posedge clk) begin
		sap_result_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (placements_q.size() == 0) begin
					$display("%0t: response word with none expected: fits %0d x %0d y %0d margin %0d",
						$time, rsp_ch.fits, rsp_ch.place_x, rsp_ch.place_y,
						rsp_ch.texel_margin);
					mismatches++;
				end else begin
					want = placements_q.pop_front();
					words_checked++;
					if (want.fits)
						placed_cnt++;
					else
						refused_cnt++;
					if (rsp_ch.fits !== want.fits) begin
						$display("%0t: fits expected %0d actual %0d",
							$time, want.fits, rsp_ch.fits);
						mismatches++;
					end
					if (rsp_ch.place_x !== want.place_x) begin
						$display("%0t: place_x expected %0d actual %0d",
							$time, want.place_x, rsp_ch.place_x);
						mismatches++;
					end
					if (rsp_ch.place_y !== want.place_y) begin
						$display("%0t: place_y expected %0d actual %0d",
							$time, want.place_y, rsp_ch.place_y);
						mismatches++;
					end
					if (rsp_ch.texel_margin !== want.texel_margin) begin
						$display("%0t: texel_margin expected %0d actual %0d",
							$time, want.texel_margin, rsp_ch.texel_margin);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog: any word moving on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clk                      = 1'b0;
		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_index                = CFG_ATLAS_WIDTH;
		cfg_data                 = '0;
		req_ch.valid             = 1'b0;
		req_ch.glyph_width       = '0;
		req_ch.glyph_height      = '0;
		req_ch.font_res_vertical = '0;
		rsp_ch.ready             = 1'b0;
		atlas_w_cfg              = ATLAS_SIZE_RESET;
		atlas_h_cfg              = ATLAS_SIZE_RESET;
		df_mode_cfg              = 1'b0;
		shelf_base               = '0;
		shelf_fill               = '0;
		shelf_top                = '0;
		mismatches               = 0;
		words_sent               = 0;
		words_checked            = 0;
		placed_cnt               = 0;
		refused_cnt              = 0;
		setting_cnt              = 0;
		// The sender is mostly busy and the receiver mostly stalls to begin with.
		send_idle_pct            = 15;
		recv_idle_pct            = 71;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words at the reset settings (greyscale, 1024 by 1024): empty and tiny
		// glyphs, a resolution that greyscale ignores, a box filling most of the row,
		// one that must open a new row, and boxes too wide or too tall for the atlas.
		queue_glyph(0, 0, 0);
		queue_glyph(1, 1, 0);
		queue_glyph(5, 2, 8191);
		queue_glyph(600, 10, 0);
		queue_glyph(200, 10, 0);
		queue_glyph(1024, 0, 0);
		queue_glyph(1, 1024, 0);
		queue_glyph(2047, 2047, 8191);
		queue_glyph(3, 3, 0);

		// Directed words with the effect margin: the floor of two texels at low
		// resolutions, the step from two to three, and the largest margins.
		set_atlas(1024, 1024, 1'b1);
		queue_glyph(0, 0, 0);
		queue_glyph(10, 10, 11);
		queue_glyph(10, 10, 12);
		queue_glyph(10, 10, 17);
		queue_glyph(10, 10, 18);
		queue_glyph(2047, 0, 6);
		queue_glyph(0, 2047, 6);
		queue_glyph(0, 0, 8191);
		queue_glyph(2047, 2047, 8191);

		// A narrow atlas stacks many short rows; then a full-size one with margins,
		// and a one-texel-wide atlas that refuses everything.
		set_atlas(256, 8191, 1'b0);
		queue_random_glyphs(60);
		set_atlas(8191, 8191, 1'b1);
		queue_random_glyphs(80);
		set_atlas(1, 8191, 1'b0);
		queue_random_glyphs(20);

		// Now the receiver is mostly ready and the sender mostly idle.
		send_idle_pct = 71;
		recv_idle_pct = 15;
		set_atlas(0, 0, 1'b1);
		queue_random_glyphs(20);
		set_atlas(4096, 4096, 1'b0);
		queue_random_glyphs(60);
		set_atlas(8191, 8191, 1'b0);
		queue_random_glyphs(120);

		// Full rate on both sides. Shrinking the width below the current row's fill
		// makes the room in the row negative.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_atlas(64, 8191, 1'b1);
		queue_random_glyphs(40);
		set_atlas(2048, 8191, 1'b0);
		queue_random_glyphs(100);

		while (pend_q.size() != 0 || req_ch.valid || placements_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d request words over %0d atlas settings after reset.",
			words_sent, setting_cnt);
		$display("Responses checked: %0d, of which %0d placed and %0d refused.",
			words_checked, placed_cnt, refused_cnt);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
